// ===== hdl/pdf_pkg.sv =====
// Shared widths, register indexes and arithmetic helpers for the pixel deglitch filter.
// No dependencies.
package pdf_pkg;

    localparam int PIX_W  = 4;
    localparam int CHAR_W = 7;
    localparam int FW_W   = 6;
    localparam int FH_W   = 10;
    localparam int TH_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = FH_W;
    localparam int SUM_W  = 6;
    localparam int CNT_W  = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_THRESHOLD = 2'd2;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST      = 6'd30;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST     = 10'd20;
    localparam logic [TH_W-1:0] GLITCH_THRESHOLD_RST = 4'd1;

    // Round-half-up average floor((2*sum + n) / (2*n)) for n = 2, 3, 4.
    function automatic logic [PIX_W-1:0] pdf_avg(input logic [SUM_W-1:0] sum,
                                                 input logic [CNT_W-1:0] cnt);
        logic [SUM_W:0]   half2;
        logic [SUM_W:0]   half4;
        logic [SUM_W:0]   x3;
        logic [12:0]      prod3;
        logic [PIX_W-1:0] avg;
        half2 = {1'b0, sum} + 7'd1;
        half4 = {1'b0, sum} + 7'd2;
        x3    = {sum, 1'b0} + 7'd3;
        // x / 6 via x * 43 / 256, exact for x below 128
        prod3 = 13'(x3) * 13'd43;
        unique case (cnt)
            3'd2:    avg = half2[PIX_W:1];
            3'd3:    avg = prod3[11:8];
            3'd4:    avg = half4[PIX_W+1:2];
            default: avg = '0;
        endcase
        return avg;
    endfunction

    // Shade map " .':~*=&%#"
    function automatic logic [CHAR_W-1:0] pdf_shade(input logic [PIX_W-1:0] v);
        logic [CHAR_W-1:0] ch;
        unique case (v)
            4'd0:    ch = 7'd32;
            4'd1:    ch = 7'd46;
            4'd2:    ch = 7'd39;
            4'd3:    ch = 7'd58;
            4'd4:    ch = 7'd126;
            4'd5:    ch = 7'd42;
            4'd6:    ch = 7'd61;
            4'd7:    ch = 7'd38;
            4'd8:    ch = 7'd37;
            default: ch = 7'd35;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/pixel_deglitch_filter_top.sv =====
// Pixel deglitch filter: four-neighbor average with threshold replacement, raster order.
// Depends on pdf_pkg, pdf_ram. A first-row pixel is only stored and gives no result; any
// other pixel has its result (for the row above) registered after RD0, RD1, RD2 and CALC,
// with the input ready again in that same cycle; no new pixel is taken before then, as the
// three reads of the center row share one store's read port. The end-of-frame flush runs
// RD0 to CALC for each column. Output stalls hold CALC. Synchronous active-low reset
// returns to frame start with reset geometry; line stores are not cleared.
module pixel_deglitch_filter_top
    import pdf_pkg::*;
#(
    parameter int MAX_COLS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [CHAR_W-1:0]     o_shade_char,
    output logic                  o_row_end,
    output logic                  o_frame_end,
    output logic                  o_run_last
);

    localparam int AW = $clog2(MAX_COLS);
    localparam logic [FW_W:0] MaxColsExt = (FW_W+1)'(MAX_COLS);

    typedef enum logic [2:0] {S_IDLE, S_RD0, S_RD1, S_RD2, S_CALC} t_state;

    // Control state
    t_state          r_state;
    logic            r_flush;       // sweeping the last row after the final pixel
    logic            r_sel;         // 1: store B holds the last completed row
    logic [AW-1:0]   r_col_count;
    logic [FH_W-1:0] r_row_count;
    logic            r_out_valid;

    // Configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [TH_W-1:0] r_thr;

    // Per-item working registers
    logic [AW-1:0]    r_k;          // column being filtered
    logic [FH_W-1:0]  r_row;        // row of the accepted pixel
    logic [PIX_W-1:0] r_p;
    logic             r_last_px;    // accepted pixel closes the frame
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_mid;

    // Output register payload
    logic [PIX_W-1:0]  r_pixel_out;
    logic [CHAR_W-1:0] r_shade_char;
    logic              r_row_end;
    logic              r_frame_end;
    logic              r_run_last;

    // Effective geometry: width clamped to 2..MAX_COLS, height at least 2
    logic [AW-1:0]   w_last;
    logic [FH_W-1:0] h_last;

    always_comb begin
        priority if (r_frame_width < 6'd2) begin
            w_last = AW'(1);
        end else if ({1'b0, r_frame_width} > MaxColsExt) begin
            w_last = AW'(MAX_COLS - 1);
        end else begin
            w_last = AW'(r_frame_width - 6'd1);
        end
        h_last = (r_frame_height < 10'd2) ? 10'd1 : r_frame_height - 10'd1;
    end

    // Position of the incoming pixel, clamped to the current geometry
    logic [AW-1:0]    c_in;
    logic [FH_W-1:0]  r_in;
    logic [PIX_W-1:0] p_sat;
    logic             in_xfer;

    assign c_in    = (r_col_count > w_last) ? w_last : r_col_count;
    assign r_in    = (r_row_count > h_last) ? h_last : r_row_count;
    assign p_sat   = (i_pixel_in > PIX_MAX) ? PIX_MAX : i_pixel_in;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Line store access. X is the row being filtered (read at k-1, k, k+1),
    // Y the row above it (read at k). In flush mode the roles of the stores swap.
    logic            x_is_a;
    logic [AW-1:0]   x_addr;
    logic            rd_en;
    logic [PIX_W-1:0] a_rd_data, b_rd_data, x_data, y_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic            emit;

    assign x_is_a = ~(r_sel ^ r_flush);

    always_comb begin
        unique case (r_state)
            S_RD0:   x_addr = r_k - AW'(1);
            S_RD1:   x_addr = r_k;
            default: x_addr = r_k + AW'(1);
        endcase
    end

    assign rd_en  = (r_state == S_RD0) || (r_state == S_RD1) || (r_state == S_RD2);
    assign x_data = x_is_a ? a_rd_data : b_rd_data;
    assign y_data = x_is_a ? b_rd_data : a_rd_data;

    // Store the new pixel into the row under construction: at once for the first row,
    // otherwise once its column above has been read and filtered.
    assign wr_en   = (in_xfer && (r_in == '0)) ||
                     ((r_state == S_CALC) && !r_flush && emit);
    assign wr_addr = in_xfer ? c_in : r_k;
    assign wr_data = in_xfer ? p_sat : r_p;

    pdf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS),
        .ADDR_W(AW)
    ) u_store_a (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en && r_sel),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(x_is_a ? x_addr : r_k),
        .o_rd_data(a_rd_data)
    );

    pdf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS),
        .ADDR_W(AW)
    ) u_store_b (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en && !r_sel),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(x_is_a ? r_k : x_addr),
        .o_rd_data(b_rd_data)
    );

    // Filter arithmetic; the right neighbor comes straight from the held read data
    logic             has_left, has_right, has_up;
    logic [PIX_W-1:0] base;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] avg, diff, result;
    logic             at_row_end;

    always_comb begin
        has_left  = (r_k != '0);
        has_right = (r_k != w_last);
        has_up    = !r_flush && (r_row >= 10'd2);
        base      = r_flush ? r_up : r_p;
        sum = SUM_W'(base)
            + (has_up    ? SUM_W'(r_up)   : '0)
            + (has_left  ? SUM_W'(r_left) : '0)
            + (has_right ? SUM_W'(x_data) : '0);
        cnt = CNT_W'(1) + CNT_W'(has_up) + CNT_W'(has_left) + CNT_W'(has_right);
        avg    = pdf_avg(sum, cnt);
        diff   = (r_mid > avg) ? r_mid - avg : avg - r_mid;
        result = (diff > r_thr) ? avg : r_mid;
    end

    assign at_row_end = (r_k == w_last);
    assign emit = (r_state == S_CALC) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_flush        <= 1'b0;
            r_sel          <= 1'b0;
            r_col_count    <= '0;
            r_row_count    <= '0;
            r_out_valid    <= 1'b0;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_thr          <= GLITCH_THRESHOLD_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:      r_frame_width  <= i_cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT:     r_frame_height <= i_cfg_data[FH_W-1:0];
                    CFG_GLITCH_THRESHOLD: r_thr          <= i_cfg_data[TH_W-1:0];
                    default: ;
                endcase
            end

            // Output register: load on emit, drop once taken
            if (emit) begin
                r_out_valid  <= 1'b1;
                r_pixel_out  <= result;
                r_shade_char <= pdf_shade(result);
                r_row_end    <= at_row_end;
                r_frame_end  <= r_flush && at_row_end;
                r_run_last   <= r_flush ? at_row_end : !r_last_px;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_p       <= p_sat;
                        r_k       <= c_in;
                        r_row     <= r_in;
                        r_last_px <= (r_in == h_last) && (c_in == w_last);
                        if (r_in == '0) begin
                            // first row: store only, advance position
                            if (c_in == w_last) begin
                                r_col_count <= '0;
                                r_row_count <= r_in + 10'd1;
                                r_sel       <= ~r_sel;
                            end else begin
                                r_col_count <= c_in + AW'(1);
                                r_row_count <= r_in;
                            end
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_left  <= x_data;
                    r_up    <= y_data;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_mid   <= x_data;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (emit) begin
                        if (r_flush) begin
                            if (at_row_end) begin
                                r_flush     <= 1'b0;
                                r_col_count <= '0;
                                r_row_count <= '0;
                                r_sel       <= ~r_sel;
                                r_state     <= S_IDLE;
                            end else begin
                                r_k     <= r_k + AW'(1);
                                r_state <= S_RD0;
                            end
                        end else if (r_last_px) begin
                            // final pixel stored: sweep the last row
                            r_flush <= 1'b1;
                            r_k     <= '0;
                            r_state <= S_RD0;
                        end else begin
                            if (at_row_end) begin
                                r_col_count <= '0;
                                r_row_count <= r_row + 10'd1;
                                r_sel       <= ~r_sel;
                            end else begin
                                r_col_count <= r_k + AW'(1);
                                r_row_count <= r_row;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_shade_char = r_shade_char;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;
    assign o_run_last   = r_run_last;

    // The working column never leaves the current row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k <= w_last))
        else $error("working column beyond last column");

    // A finished flush leaves the position at frame start
    a_flush_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_flush && at_row_end) |=> (r_row_count == '0) && (r_col_count == '0))
        else $error("flush did not rewind the frame position");

    // The frame's last result closes its row and its run
    a_frame_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_end) |-> (r_row_end && r_run_last))
        else $error("frame end without row end or run end");

    // A result appears only out of the compute step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_CALC))
        else $error("result loaded outside the compute step");

endmodule

// ===== hdl/pdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pdf_ram #(
    parameter int WIDTH  = 4,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
